[rtl/rrwd_pkg.sv]
// Shared types, codes and constants of the RLE RGB888 window decoder.
package rrwd_pkg;

  // Default for the largest image or frame dimension in pixels
  localparam int MAX_DIMENSION_DEF = 4096;

  // Fixed field widths
  localparam int DIM_W   = 13;
  localparam int ORG_W   = 12;
  localparam int ADDR_W  = 24;
  localparam int PROD_W  = 2 * DIM_W;
  localparam int COLOR_W = 24;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_RUN = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

  // Input record
  typedef struct packed {
    logic       start_of_image;
    logic [7:0] run_length;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rec_t;

  // Output write segment
  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        segment_length;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic              last_of_run;
    logic              image_complete;
    logic [1:0]        status;
  } seg_t;

  // Configuration registers
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
  } cfg_t;

  // Command class decided by the front end
  typedef enum logic [1:0] {
    CMD_RECORD,
    CMD_START,
    CMD_BAD_SIZE
  } cmd_kind_t;

  // Queue entry: the record plus the image setup latched at a start
  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         run_length;
    logic [COLOR_W-1:0] color;
    logic [PROD_W-1:0]  pixel_total;
    logic [ADDR_W-1:0]  base_address;
    logic [DIM_W-1:0]   line_skip;
    logic [DIM_W-1:0]   width;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

[rtl/rrwd_front.sv]
// Front end: accepts records, computes the image setup and classifies each request.
module rrwd_front #(
  parameter int MAX_DIMENSION = rrwd_pkg::MAX_DIMENSION_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rrwd_pkg::cfg_t cfg,
  input  logic          rec_valid,
  output logic          rec_stall,
  input  rrwd_pkg::rec_t rec,
  output logic          push,
  output rrwd_pkg::cmd_t entry,
  input  logic          full
);
  import rrwd_pkg::*;

  logic              f_valid;
  rec_t              f_rec;
  logic [PROD_W-1:0] img_px;
  logic [PROD_W-1:0] frm_px;
  logic [PROD_W-2:0] base_prod;
  logic              accept;
  logic              bad_size;
  logic [PROD_W-1:0] base_sum;

  assign rec_stall = f_valid && full;
  assign accept    = rec_valid && !rec_stall;
  assign push      = f_valid && !full;

  // Holding stage with registered products of the configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_rec     <= rec;
      img_px    <= PROD_W'(cfg.image_width) * PROD_W'(cfg.image_height);
      frm_px    <= PROD_W'(cfg.frame_width) * PROD_W'(cfg.frame_height);
      base_prod <= (PROD_W-1)'(cfg.origin_y) * (PROD_W-1)'(cfg.frame_width);
    end
  end

  // Size check at a start
  always_comb begin
    bad_size = (cfg.image_width < DIM_W'(8))
            || (32'(cfg.image_width) > MAX_DIMENSION)
            || (cfg.image_height == '0)
            || (32'(cfg.image_height) > MAX_DIMENSION)
            || (32'(cfg.frame_width) > MAX_DIMENSION)
            || (32'(cfg.frame_height) > MAX_DIMENSION)
            || (cfg.image_width > cfg.frame_width)
            || (img_px > frm_px);
  end

  assign base_sum = PROD_W'(base_prod) + PROD_W'(cfg.origin_x);

  // Queue entry
  always_comb begin
    if (!f_rec.start_of_image) begin
      entry.kind = CMD_RECORD;
    end else if (bad_size) begin
      entry.kind = CMD_BAD_SIZE;
    end else begin
      entry.kind = CMD_START;
    end
    entry.run_length   = f_rec.run_length;
    entry.color        = {f_rec.red_in, f_rec.green_in, f_rec.blue_in};
    entry.pixel_total  = img_px;
    entry.base_address = base_sum[ADDR_W-1:0];
    entry.line_skip    = cfg.frame_width - cfg.image_width;
    entry.width        = cfg.image_width;
  end

endmodule

[rtl/rrwd_queue.sv]
// Two-entry command queue between the front and back ends.
module rrwd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrwd_pkg::cmd_t entry,
  input  logic           pop,
  output rrwd_pkg::cmd_t head,
  output logic           valid,
  output logic           full
);
  import rrwd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign valid = (count != '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

[rtl/rrwd_back.sv]
// Back end: splits each run into row-bounded segments and holds the output register.
module rrwd_back #(
  parameter int MAX_DIMENSION = rrwd_pkg::MAX_DIMENSION_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rrwd_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           seg_valid,
  input  logic           seg_stall,
  output rrwd_pkg::seg_t seg
);
  import rrwd_pkg::*;

  localparam int PXW = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);

  back_state_t        state;
  back_state_t        state_next;
  logic               halted;
  logic [PXW-1:0]     pixels_left;
  logic [DIM_W-1:0]   column_count;
  logic [ADDR_W-1:0]  next_address;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   skip_q;
  logic [7:0]         run_q;
  logic [COLOR_W-1:0] color_q;

  logic               emit_ok;
  logic               emit;
  seg_t               emit_seg;
  logic               is_start;
  logic               halted_eff;
  logic [7:0]         clip_run;
  logic [DIM_W-1:0]   room;
  logic [7:0]         seg_len;
  logic               seg_last;
  logic [PXW-1:0]     pl_after;
  logic [DIM_W-1:0]   col_after;
  logic               row_wrap;
  logic [ADDR_W-1:0]  addr_after;

  assign emit_ok    = !seg_valid || !seg_stall;
  assign is_start   = (head.kind == CMD_START);
  assign halted_eff = is_start ? 1'b0 : halted;

  // Segment arithmetic for the run in progress
  always_comb begin
    clip_run   = (PXW'(run_q) < pixels_left) ? run_q : pixels_left[7:0];
    room       = width_q - column_count;
    seg_len    = (DIM_W'(clip_run) < room) ? clip_run : room[7:0];
    seg_last   = (seg_len == clip_run);
    pl_after   = pixels_left - PXW'(seg_len);
    col_after  = column_count + DIM_W'(seg_len);
    row_wrap   = (col_after >= width_q);
    addr_after = next_address + ADDR_W'(seg_len)
               + (row_wrap ? ADDR_W'(skip_q) : '0);
  end

  // Sequencer: next state, pop and the result to emit
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_seg   = '0;
    emit_seg.last_of_run = 1'b1;
    case (state)
      BK_IDLE: begin
        if (head_valid && emit_ok) begin
          pop = 1'b1;
          if (head.kind == CMD_BAD_SIZE) begin
            emit            = 1'b1;
            emit_seg.status = STATUS_BAD_SIZE;
          end else if (halted_eff) begin
            emit = 1'b1;
          end else if (head.run_length == '0) begin
            emit            = 1'b1;
            emit_seg.status = STATUS_ZERO_RUN;
          end else begin
            state_next = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        if (emit_ok) begin
          emit                    = 1'b1;
          emit_seg.write_address  = next_address;
          emit_seg.segment_length = seg_len;
          emit_seg.red_out        = color_q[23:16];
          emit_seg.green_out      = color_q[15:8];
          emit_seg.blue_out       = color_q[7:0];
          emit_seg.last_of_run    = seg_last;
          emit_seg.image_complete = seg_last && (pl_after == '0);
          emit_seg.status         = STATUS_OK;
          if (seg_last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode position and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      halted       <= 1'b1;
      pixels_left  <= '0;
      column_count <= '0;
      next_address <= '0;
      width_q      <= '0;
      skip_q       <= '0;
    end else if (state == BK_IDLE) begin
      if (pop) begin
        if (head.kind == CMD_BAD_SIZE) begin
          halted <= 1'b1;
        end else begin
          if (is_start) begin
            pixels_left  <= PXW'(head.pixel_total);
            column_count <= '0;
            next_address <= head.base_address;
            width_q      <= head.width;
            skip_q       <= head.line_skip;
          end
          if (!halted_eff) begin
            halted <= (head.run_length == '0);
          end
        end
      end
    end else if (emit) begin
      pixels_left  <= pl_after;
      column_count <= row_wrap ? '0 : col_after;
      next_address <= addr_after;
      if (seg_last && (pl_after == '0)) begin
        halted <= 1'b1;
      end
    end
  end

  // Working run and color
  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      if (pop) begin
        run_q   <= head.run_length;
        color_q <= head.color;
      end
    end else if (emit) begin
      run_q <= run_q - seg_len;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (emit) begin
      seg_valid <= 1'b1;
    end else if (!seg_stall) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg <= emit_seg;
    end
  end

endmodule

[rtl/rle_rgb888_window_decoder_unit.sv]
// Top level of the RLE RGB888 window decoder: register port and the front/queue/back chain.
//
// Takes run-length records (count plus RGB888 color) and turns each into write
// segments that never cross a row of the image window, addressed in pixels from
// the framebuffer base. The front end holds each record in a register stage with the
// window products for the size check and setup, then hands it through a two-entry
// queue to the back end. The back end takes each record's command in its idle state
// and then emits the record's segments from its run state; a record that gives an
// error or halted result is answered from the idle state alone. That back-end
// sequencer, emitting one segment per cycle while the output is not stalled, sets
// the rate. Errors (zero run, invalid image size) and a finished image halt decoding
// until the next start_of_image. Registers sit at byte addresses 4*i, are always
// ready and read back; write them only when no records are in flight.
module rle_rgb888_window_decoder_unit #(
  parameter int MAX_DIMENSION = rrwd_pkg::MAX_DIMENSION_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           rec_valid,
  output logic           rec_stall,
  input  rrwd_pkg::rec_t rec,
  output logic           seg_valid,
  input  logic           seg_stall,
  output rrwd_pkg::seg_t seg
);
  import rrwd_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [2:0] reg_index;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  logic       q_full;
  cmd_t       q_entry;
  cmd_t       q_head;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= DIM_W'(8);
      cfg.image_height <= DIM_W'(1);
      cfg.frame_width  <= DIM_W'(8);
      cfg.frame_height <= DIM_W'(1);
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[DIM_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        REG_ORIGIN_X:     cfg.origin_x     <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= pwdata[ORG_W-1:0];
        default:          ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_index)
      REG_IMAGE_WIDTH:  prdata = 32'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg.image_height);
      REG_FRAME_WIDTH:  prdata = 32'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      REG_ORIGIN_X:     prdata = 32'(cfg.origin_x);
      REG_ORIGIN_Y:     prdata = 32'(cfg.origin_y);
      default:          prdata = '0;
    endcase
  end

  rrwd_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .push      (q_push),
    .entry     (q_entry),
    .full      (q_full)
  );

  rrwd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .entry (q_entry),
    .pop   (q_pop),
    .head  (q_head),
    .valid (q_valid),
    .full  (q_full)
  );

  rrwd_back #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg)
  );

  // An empty queue always leaves room, so the record port never stalls then
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !rec_stall)
    else $error("record port stalled with an empty queue");

  // Completion only on the final segment of a record
  a_complete_is_last: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.image_complete |-> seg.last_of_run && seg.status == STATUS_OK)
    else $error("image_complete on a non-final or error result");

  // Error results carry no pixels and end their record
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.status != STATUS_OK |-> seg.segment_length == '0 && seg.last_of_run)
    else $error("error result with pixels or without last_of_run");

  // The back end never pops an empty queue
  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

[test/rle_paint_checker.sv]
// Checker for the RLE window decoder: predicts each request's write segments and compares them.
module rle_paint_checker #(
  parameter int MAX_DIM = rrwd_pkg::MAX_DIMENSION_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  input  logic           rec_valid,
  input  logic           rec_stall,
  input  rrwd_pkg::rec_t rec,
  input  logic           seg_valid,
  input  logic           seg_stall,
  input  rrwd_pkg::seg_t seg,
  output int             mismatches,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrwd_pkg::*;

  localparam int MAX_LINES = 200;

  // Local copies of the window registers
  logic [DIM_W-1:0]  img_w, img_h, frm_w, frm_h;
  logic [ORG_W-1:0]  org_x, org_y;

  // Paint position, latched window width and line skip
  int unsigned       pix_left, col, win_w, skip;
  logic [ADDR_W-1:0] next_addr;
  bit                halted;

  // Segments predicted but not yet seen on the output
  seg_t              segs_due[$];
  int                seg_count;
  int                lines_out;

  function automatic bit size_ok();
    int unsigned iw, ih, fw, fh;
    iw = 32'(img_w);
    ih = 32'(img_h);
    fw = 32'(frm_w);
    fh = 32'(frm_h);
    if (iw < 8 || iw > MAX_DIM) return 1'b0;
    if (ih == 0 || ih > MAX_DIM) return 1'b0;
    if (fw > MAX_DIM || fh > MAX_DIM) return 1'b0;
    if (iw > fw) return 1'b0;
    if (iw * ih > fw * fh) return 1'b0;
    return 1'b1;
  endfunction

  // Single empty result that closes an error or halted request
  task automatic queue_flag(input logic [1:0] code);
    seg_t s;
    s = '0;
    s.last_of_run = 1'b1;
    s.status = code;
    segs_due.push_back(s);
  endtask

  // Split one run into row-bounded segments
  task automatic paint_record(input rec_t r);
    int unsigned run, room, len;
    seg_t s;
    if (r.start_of_image) begin
      if (!size_ok()) begin
        halted = 1'b1;
        queue_flag(STATUS_BAD_SIZE);
        return;
      end
      pix_left = 32'(img_w) * 32'(img_h);
      col = 0;
      win_w = 32'(img_w);
      skip = 32'(frm_w) - 32'(img_w);
      next_addr = ADDR_W'(32'(org_y) * 32'(frm_w) + 32'(org_x));
      halted = 1'b0;
    end
    if (halted) begin
      queue_flag(STATUS_OK);
      return;
    end
    if (r.run_length == 8'd0) begin
      halted = 1'b1;
      queue_flag(STATUS_ZERO_RUN);
      return;
    end
    run = 32'(r.run_length);
    if (run > pix_left) run = pix_left;
    while (run > 0) begin
      room = win_w - col;
      len = (run < room) ? run : room;
      s = '0;
      s.write_address = next_addr;
      s.segment_length = 8'(len);
      s.red_out = r.red_in;
      s.green_out = r.green_in;
      s.blue_out = r.blue_in;
      run -= len;
      pix_left -= len;
      col += len;
      next_addr = next_addr + ADDR_W'(len);
      // row done: jump over the frame outside the window
      if (col >= win_w) begin
        col = 0;
        next_addr = next_addr + ADDR_W'(skip);
      end
      s.last_of_run = (run == 0);
      s.image_complete = (run == 0) && (pix_left == 0);
      s.status = STATUS_OK;
      segs_due.push_back(s);
    end
    if (pix_left == 0) halted = 1'b1;
  endtask

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input int unsigned got);
    if (want == got) return 1'b1;
    if (lines_out < MAX_LINES) begin
      $display("%0t ns: segment %0d %s expected %0h actual %0h",
               $time, seg_count, name, want, got);
      lines_out++;
    end
    return 1'b0;
  endfunction

  task automatic check_seg(input seg_t got);
    seg_t want;
    bit ok;
    if (segs_due.size() == 0) begin
      mismatches++;
      if (lines_out < MAX_LINES) begin
        $display("%0t ns: segment %0d expected none actual addr %0h len %0d status %0d",
                 $time, seg_count, got.write_address, got.segment_length, got.status);
        lines_out++;
      end
      seg_count++;
      return;
    end
    want = segs_due.pop_front();
    ok = field_ok("write_address", 32'(want.write_address), 32'(got.write_address));
    ok = field_ok("segment_length", 32'(want.segment_length),
                  32'(got.segment_length)) & ok;
    ok = field_ok("red_out", 32'(want.red_out), 32'(got.red_out)) & ok;
    ok = field_ok("green_out", 32'(want.green_out), 32'(got.green_out)) & ok;
    ok = field_ok("blue_out", 32'(want.blue_out), 32'(got.blue_out)) & ok;
    ok = field_ok("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run)) & ok;
    ok = field_ok("image_complete", 32'(want.image_complete),
                  32'(got.image_complete)) & ok;
    ok = field_ok("status", 32'(want.status), 32'(got.status)) & ok;
    if (!ok) mismatches++;
    seg_count++;
  endtask

  // Register writes, then output compare, then new requests
  always @(posedge clk) begin
    if (rst) begin
      img_w = 13'd8;
      img_h = 13'd1;
      frm_w = 13'd8;
      frm_h = 13'd1;
      org_x = '0;
      org_y = '0;
      pix_left = 0;
      col = 0;
      win_w = 0;
      skip = 0;
      next_addr = '0;
      halted = 1'b1;
      segs_due.delete();
      seg_count = 0;
      lines_out = 0;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IMAGE_WIDTH:  img_w = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: img_h = pwdata[DIM_W-1:0];
          REG_FRAME_WIDTH:  frm_w = pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT: frm_h = pwdata[DIM_W-1:0];
          REG_ORIGIN_X:     org_x = pwdata[ORG_W-1:0];
          REG_ORIGIN_Y:     org_y = pwdata[ORG_W-1:0];
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall) check_seg(seg);
      if (rec_valid && !rec_stall) paint_record(rec);
    end
    outstanding = segs_due.size();
  end

endmodule

[test/testbench.sv]
// Top of the RLE window decoder testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrwd_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_RECORDS = 80;
  localparam int TAIL_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rec_valid = 1'b0;
  logic        rec_stall;
  rec_t        rec = '0;
  logic        seg_valid;
  logic        seg_stall = 1'b0;
  seg_t        seg;

  // no idling on either side while set
  logic        calm = 1'b0;
  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  int          rand_recs = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rle_rgb888_window_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg)
  );

  rle_paint_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .rec_valid   (rec_valid),
    .rec_stall   (rec_stall),
    .rec         (rec),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .seg         (seg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Random backpressure on the segment side
  always @(posedge clk) begin
    seg_stall <= !calm && ($urandom_range(99) < 19);
  end

  // Watchdog: cycles without any request moving
  always @(posedge clk) begin
    if (rst || (rec_valid && !rec_stall) || (seg_valid && !seg_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One record request; valid stays high on return so back-to-back requests flow
  task automatic put_rec(input logic sos, input logic [7:0] len, input logic [23:0] rgb);
    while (!calm && $urandom_range(99) < 19) begin
      rec_valid <= 1'b0;
      @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec <= '{start_of_image: sos, run_length: len,
             red_in: rgb[23:16], green_in: rgb[15:8], blue_in: rgb[7:0]};
    do @(posedge clk); while (rec_stall);
  endtask

  // Stop sending and wait for every predicted segment
  task automatic drain();
    rec_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(input int unsigned iw, input int unsigned ih,
                         input int unsigned fw, input int unsigned fh,
                         input int unsigned ox, input int unsigned oy);
    drain();
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
  endtask

  initial begin
    int unsigned iw, ih, fw, fh;
    int n, p;
    logic [7:0] len;
    logic sos;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset window: record before any start, clipped run, record after completion
    put_rec(1'b0, 8'd5, 24'h123456);
    put_rec(1'b1, 8'd3, 24'hff00ff);
    put_rec(1'b0, 8'd255, 24'h00ff00);
    put_rec(1'b0, 8'd1, 24'hffffff);

    // Offset window: runs across rows, zero run, halted, oversized run
    set_cfg(8, 4, 16, 8, 3, 2);
    put_rec(1'b1, 8'd20, 24'haa55aa);
    put_rec(1'b0, 8'd0, 24'h55aa55);
    put_rec(1'b0, 8'd7, 24'h0f0f0f);
    put_rec(1'b1, 8'd255, 24'hffffff);

    // Register change mid image: width and skip stay latched
    put_rec(1'b1, 8'd10, 24'h010203);
    drain();
    write_reg(REG_IMAGE_WIDTH, 16);
    write_reg(REG_FRAME_WIDTH, 32);
    put_rec(1'b0, 8'd30, 24'h040506);

    // Largest frame at the far corner: address wraps
    set_cfg(4096, 4096, 4096, 4096, 4095, 4095);
    put_rec(1'b1, 8'd200, 24'h800001);
    put_rec(1'b0, 8'd255, 24'h7ffffe);

    // Invalid sizes, each checked at a start
    set_cfg(7, 1, 8, 1, 0, 0);
    put_rec(1'b1, 8'd4, 24'h111111);
    set_cfg(4097, 1, 4096, 1, 0, 0);
    put_rec(1'b1, 8'd4, 24'h222222);
    set_cfg(8, 0, 8, 1, 0, 0);
    put_rec(1'b1, 8'd4, 24'h333333);
    set_cfg(8, 4097, 4096, 4096, 0, 0);
    put_rec(1'b1, 8'd4, 24'h444444);
    set_cfg(8, 1, 8191, 1, 0, 0);
    put_rec(1'b1, 8'd4, 24'h555555);
    set_cfg(8, 1, 8, 8191, 0, 0);
    put_rec(1'b1, 8'd4, 24'h666666);
    set_cfg(16, 1, 8, 8, 0, 0);
    put_rec(1'b1, 8'd4, 24'h777777);
    set_cfg(8, 3, 8, 2, 0, 0);
    put_rec(1'b1, 8'd4, 24'h888888);
    put_rec(1'b0, 8'd9, 24'h999999);

    // Random images: mostly well-formed, some noise and broken sequences
    while (rand_recs < RANDOM_RECORDS) begin
      calm <= (rand_recs >= 40 && rand_recs < 75);
      p = $urandom_range(99);
      if (p < 12) begin
        set_cfg($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                $urandom_range(8191), $urandom_range(4095), $urandom_range(4095));
      end else if (p < 20) begin
        iw = $urandom_range(4096, 1024);
        ih = $urandom_range(4096, 1);
        fw = $urandom_range(4096, iw);
        fh = $urandom_range(4096, ih);
        set_cfg(iw, ih, fw, fh, $urandom_range(4095), $urandom_range(4095));
      end else if (p < 70) begin
        iw = $urandom_range(24, 8);
        ih = $urandom_range(6, 1);
        fw = iw + $urandom_range(20);
        fh = ih + $urandom_range(4);
        set_cfg(iw, ih, fw, fh, $urandom_range(4095), $urandom_range(4095));
      end
      n = $urandom_range(10, 2);
      for (int k = 0; k < n; k++) begin
        if (k == 0) sos = ($urandom_range(99) < 92);
        else sos = ($urandom_range(99) < 4);
        p = $urandom_range(99);
        if (p < 5) len = 8'd0;
        else if (p < 75) len = 8'($urandom_range(40, 1));
        else len = 8'($urandom_range(255, 1));
        put_rec(sos, len, 24'($urandom()));
        rand_recs++;
      end
    end

    // Let the last segments out, then a short tail for stray output
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
